[rtl/core/mse_pkg.sv]
// shared types and constants for the merge sort engine
package mse_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_MERGE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic wr_bank;
        logic rd_bank;
    } t_store_ctl;

endpackage

[rtl/core/mse_store.sv]
// ping-pong value store: two banks, one write port, two registered read ports
module mse_store #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF,
    parameter int IW        = $clog2(MAX_ITEMS)
) (
    input  logic                              i_clk,
    input  mse_pkg::t_store_ctl               i_ctl,
    input  logic [IW-1:0]                     i_wr_addr,
    input  logic signed [mse_pkg::DATA_W-1:0] i_wr_data,
    input  logic [IW-1:0]                     i_rd_addr_a,
    input  logic [IW-1:0]                     i_rd_addr_b,
    output logic signed [mse_pkg::DATA_W-1:0] o_rd_a,
    output logic signed [mse_pkg::DATA_W-1:0] o_rd_b
);
    import mse_pkg::*;

    logic signed [DATA_W-1:0] r_bank0 [MAX_ITEMS];
    logic signed [DATA_W-1:0] r_bank1 [MAX_ITEMS];
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !i_ctl.wr_bank) begin
            r_bank0[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.wr_en && i_ctl.wr_bank) begin
            r_bank1[i_wr_addr] <= i_wr_data;
        end
    end

    // read side always follows the selected source bank
    always_ff @(posedge i_clk) begin
        r_rd_a <= i_ctl.rd_bank ? r_bank1[i_rd_addr_a] : r_bank0[i_rd_addr_a];
        r_rd_b <= i_ctl.rd_bank ? r_bank1[i_rd_addr_b] : r_bank0[i_rd_addr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

[rtl/core/merge_sort_engine.sv]
// merge sort engine top level: load, bottom-up merge passes, ordered emission
//
// usage:
//   input channel (i_valid / o_ready) carries one signed value per transaction,
//   i_last closes the set. values past MAX_ITEMS are dropped and flag overflow.
//   output channel (o_valid / i_ready) returns the set in ascending order, one
//   value per transaction, o_final_res on the last one, o_overflow on all of
//   them when the set lost values.
// timing:
//   loading writes each value to the store as its transaction is taken. after
//   the closing transaction the block runs merge passes, doubling the run width
//   from one until it covers the set, each preceded by a prep step that primes
//   the registered store reads, through a single compare-and-select unit.
//   emission is one value per cycle while the receiver takes them.
//   o_ready is low from the closing transaction until the last result is taken.
// reset:
//   synchronous active-low reset empties the set and clears overflow; the
//   store contents are not cleared and need not be.
// stalls:
//   a stalled receiver holds the current result; the sequencer waits in
//   emission and resumes when i_ready returns.
module merge_sort_engine #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [mse_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [mse_pkg::DATA_W-1:0] o_sorted_value,
    output logic                              o_final_res,
    output logic                              o_overflow
);
    import mse_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);       // store address
    localparam int CW = $clog2(MAX_ITEMS + 1);   // count and run pointers
    localparam int WW = CW + 1;                  // run width, may pass n
    localparam int SW = CW + 3;                  // run geometry sums

    // sequencer state
    t_state r_state, n_state;

    // set bookkeeping
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;

    // merge pointers: i walks the left run, j the right run, k the output
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [WW-1:0] r_w, n_w;
    logic          r_bank, n_bank;   // bank holding the current source data

    // store interface
    t_store_ctl               store_ctl;
    logic [IW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;

    // handshakes
    logic in_acc;
    logic out_acc;
    logic full;
    logic [CW-1:0] cnt_after;

    // shared compare-and-select unit
    logic take_b;
    logic run_done;
    logic pass_done;

    // geometry of the next run
    logic [SW-1:0] w2;
    logic [SW-1:0] run_lo_nx;
    logic [SW-1:0] geo_base;
    logic [SW-1:0] geo_w;
    logic [SW-1:0] geo_n;
    logic [SW-1:0] mid_sum;
    logic [SW-1:0] hi_sum;
    logic [CW-1:0] geo_mid;
    logic [CW-1:0] geo_hi;

    assign in_acc    = i_valid && o_ready;
    assign out_acc   = o_valid && i_ready;
    assign full      = (r_count == CW'(MAX_ITEMS));
    assign cnt_after = full ? r_count : r_count + CW'(1);

    // right head wins only when strictly smaller, so ties keep input order
    assign take_b = (r_j < r_hi) && ((r_i >= r_mid) || (rd_b < rd_a));

    assign run_done  = ((r_k + CW'(1)) == r_hi);
    assign w2        = SW'(r_w) << 1;
    assign run_lo_nx = SW'(r_lo) + w2;
    assign pass_done = (run_lo_nx >= SW'(r_count));

    // the first pass is set up while the closing transaction is taken
    always_comb begin
        if (r_state == ST_IDLE) begin
            geo_base = '0;
            geo_w    = SW'(1);
            geo_n    = SW'(cnt_after);
        end else begin
            geo_base = pass_done ? '0 : run_lo_nx;
            geo_w    = pass_done ? w2 : SW'(r_w);
            geo_n    = SW'(r_count);
        end
    end

    assign mid_sum = geo_base + geo_w;
    assign hi_sum  = geo_base + (geo_w << 1);
    assign geo_mid = (mid_sum < geo_n) ? mid_sum[CW-1:0] : geo_n[CW-1:0];
    assign geo_hi  = (hi_sum < geo_n) ? hi_sum[CW-1:0] : geo_n[CW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_last) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = (r_w < WW'(r_count)) ? ST_MERGE : ST_EMIT;
            end
            ST_MERGE: begin
                if (run_done && pass_done) begin
                    n_state = ST_PREP;
                end
            end
            ST_EMIT: begin
                if (out_acc && o_final_res) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath next values and store control
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_w       = r_w;
        n_bank    = r_bank;
        store_ctl.wr_en   = 1'b0;
        store_ctl.wr_bank = ~r_bank;
        wr_addr = r_k[IW-1:0];
        wr_data = take_b ? rd_b : rd_a;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!full) begin
                        store_ctl.wr_en   = 1'b1;
                        store_ctl.wr_bank = 1'b0;
                        wr_addr = r_count[IW-1:0];
                        wr_data = i_value;
                        n_count = cnt_after;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last) begin
                        n_w    = WW'(1);
                        n_lo   = '0;
                        n_i    = '0;
                        n_k    = '0;
                        n_mid  = geo_mid;
                        n_j    = geo_mid;
                        n_hi   = geo_hi;
                        n_bank = 1'b0;
                    end
                end
            end
            ST_PREP: begin
                // hold pointers, the store reads their heads this cycle
            end
            ST_MERGE: begin
                store_ctl.wr_en = 1'b1;
                if (take_b) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                end
                n_k = r_k + CW'(1);
                if (run_done) begin
                    n_lo  = geo_base[CW-1:0];
                    n_i   = geo_base[CW-1:0];
                    n_k   = geo_base[CW-1:0];
                    n_mid = geo_mid;
                    n_j   = geo_mid;
                    n_hi  = geo_hi;
                    if (pass_done) begin
                        n_w    = w2[WW-1:0];
                        n_bank = ~r_bank;
                    end
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (o_final_res) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_i       = '0;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        store_ctl.rd_bank = n_bank;
    end

    // outputs
    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_valid        = (r_state == ST_EMIT);
        o_sorted_value = rd_a;
        o_final_res    = ((r_i + CW'(1)) == r_count);
        o_overflow     = r_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_lo      <= '0;
            r_mid     <= '0;
            r_hi      <= '0;
            r_w       <= '0;
            r_bank    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_lo      <= n_lo;
            r_mid     <= n_mid;
            r_hi      <= n_hi;
            r_w       <= n_w;
            r_bank    <= n_bank;
        end
    end

    // read addresses follow the next pointers so heads arrive registered
    mse_store #(
        .MAX_ITEMS (MAX_ITEMS),
        .IW        (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (store_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (n_i[IW-1:0]),
        .i_rd_addr_b (n_j[IW-1:0]),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    // output pointer never runs past the current run end
    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (r_k < r_hi && r_i <= r_mid && r_j <= r_hi))
        else $error("merge pointers out of run bounds");

    // overflow is only possible once the store is full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_count == CW'(MAX_ITEMS)))
        else $error("overflow flagged with free store space");

    // emission only ever walks a nonempty set
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0 && r_i < r_count))
        else $error("emission index outside the set");

    // taking the final result returns the block to loading
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_final_res) |=> (o_ready && r_count == '0 && !r_dropped))
        else $error("block not emptied after final result");

endmodule
